@@ hdl/assert_macros.svh @@
// Assertion macros shared by the port register bank RTL.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GPB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpb assertion failed");
// next-cycle implication
`define GPB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gpb assertion failed");
`else
`define GPB_ASSERT_IMPL(label, ante, cons)
`define GPB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/gpb_pkg.sv @@
// Shared types, register codes and pin helpers for the GPIO port register bank.
// No dependencies.
package gpb_pkg;

   localparam int PIN_COUNT = 16;
   localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_TYPE   = 3'd1;
   localparam logic [2:0] REG_SPEED  = 3'd2;
   localparam logic [2:0] REG_PULL   = 3'd3;
   localparam logic [2:0] REG_INPUT  = 3'd4;
   localparam logic [2:0] REG_OUTPUT = 3'd5;
   localparam logic [2:0] REG_BSR    = 3'd6;
   localparam logic [2:0] REG_LOCK   = 3'd7;

   localparam logic [1:0] PIN_MODE_OUT = 2'd1;
   localparam logic [1:0] PIN_MODE_ALT = 2'd2;

   localparam logic [1:0] LOCK_IDLE  = 2'd0;
   localparam logic [1:0] LOCK_KEY1  = 2'd1;
   localparam logic [1:0] LOCK_KEY2  = 2'd2;
   localparam logic [1:0] LOCK_ARMED = 2'd3;

   localparam int LOCK_KEY_BIT = 16;

   typedef struct packed {
      logic        mode;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
      logic [15:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_drive;
      logic [15:0] pin_output_enable;
   } rsp_type;

   // spread each pin bit over its 2-bit field
   function automatic logic [31:0] field_mask(input logic [15:0] pins);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[2*i +: 2] = {2{pins[i]}};
      end
      return r;
   endfunction

   function automatic logic [15:0] output_enable(input logic [31:0] modes);
      logic [15:0] oe;
      oe = '0;
      for (int i = 0; i < 16; i++) begin
         oe[i] = (modes[2*i +: 2] == PIN_MODE_OUT) || (modes[2*i +: 2] == PIN_MODE_ALT);
      end
      return oe & PIN_MASK;
   endfunction

endpackage

@@ hdl/gpb_req_reg.sv @@
// Request input register for the GPIO port register bank.
// Depends on gpb_pkg.
module gpb_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpb_pkg::req_type req_in,
   input  logic             take,
   output logic             held_valid,
   output gpb_pkg::req_type held_req
);
   import gpb_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff;
   logic    accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule

@@ hdl/gpb_reg_bank.sv @@
// Port state registers, lock sequencer and access decode.
// Depends on gpb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gpb_reg_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  gpb_pkg::req_type req,
   output gpb_pkg::rsp_type rsp
);
   import gpb_pkg::*;

   logic [31:0] mode_fields_ff,  mode_fields_in;
   logic [15:0] type_fields_ff,  type_fields_in;
   logic [31:0] speed_fields_ff, speed_fields_in;
   logic [31:0] pull_fields_ff,  pull_fields_in;
   logic [15:0] output_latch_ff, output_latch_in;
   logic [15:0] input_sample_ff, input_sample_in;
   logic [15:0] lock_mask_ff,    lock_mask_in;
   logic        lock_active_ff,  lock_active_in;
   logic [1:0]  lock_phase_ff,   lock_phase_in;

   logic [15:0] free_pins;
   logic [31:0] free_fields;
   logic [31:0] rd;
   logic [15:0] lock_wmask;
   logic        lock_key;
   logic        lock_same;

   assign free_pins   = lock_active_ff ? (PIN_MASK & ~lock_mask_ff) : PIN_MASK;
   assign free_fields = field_mask(free_pins);
   assign lock_wmask  = req.write_data[15:0] & PIN_MASK;
   assign lock_key    = req.write_data[LOCK_KEY_BIT];
   assign lock_same   = (lock_wmask == lock_mask_ff);

   always_comb begin
      mode_fields_in  = mode_fields_ff;
      type_fields_in  = type_fields_ff;
      speed_fields_in = speed_fields_ff;
      pull_fields_in  = pull_fields_ff;
      output_latch_in = output_latch_ff;
      input_sample_in = req.pin_levels & PIN_MASK;
      lock_mask_in    = lock_mask_ff;
      lock_active_in  = lock_active_ff;
      lock_phase_in   = lock_phase_ff;
      rd              = '0;
      if (req.mode == ACC_WRITE) begin
         case (req.reg_index)
            REG_MODE: begin
               mode_fields_in = (mode_fields_ff & ~free_fields) | (req.write_data & free_fields);
            end
            REG_TYPE: begin
               type_fields_in = (type_fields_ff & ~free_pins)
                              | (req.write_data[15:0] & free_pins);
            end
            REG_SPEED: begin
               speed_fields_in = (speed_fields_ff & ~free_fields)
                               | (req.write_data & free_fields);
            end
            REG_PULL: begin
               pull_fields_in = (pull_fields_ff & ~free_fields) | (req.write_data & free_fields);
            end
            REG_OUTPUT: begin
               output_latch_in = req.write_data[15:0] & PIN_MASK;
            end
            REG_BSR: begin
               // set half wins over reset half
               output_latch_in = ((output_latch_ff & ~(req.write_data[31:16] & PIN_MASK))
                                 | (req.write_data[15:0] & PIN_MASK)) & PIN_MASK;
            end
            REG_LOCK: begin
               if (!lock_active_ff) begin
                  lock_mask_in = lock_wmask;
                  if (lock_phase_ff == LOCK_IDLE && lock_key) begin
                     lock_phase_in = LOCK_KEY1;
                  end else if (lock_phase_ff == LOCK_KEY1 && !lock_key && lock_same) begin
                     lock_phase_in = LOCK_KEY2;
                  end else if (lock_phase_ff == LOCK_KEY2 && lock_key && lock_same) begin
                     lock_phase_in = LOCK_ARMED;
                  end else begin
                     lock_phase_in = lock_key ? LOCK_KEY1 : LOCK_IDLE;
                  end
               end
            end
            default: begin
               // input register write changes nothing
            end
         endcase
      end else begin
         case (req.reg_index)
            REG_MODE:   rd = mode_fields_ff;
            REG_TYPE:   rd = {16'd0, type_fields_ff};
            REG_SPEED:  rd = speed_fields_ff;
            REG_PULL:   rd = pull_fields_ff;
            REG_INPUT:  rd = {16'd0, input_sample_in};
            REG_OUTPUT: rd = {16'd0, output_latch_ff};
            REG_LOCK: begin
               if (lock_phase_ff == LOCK_ARMED) begin
                  lock_active_in = 1'b1;
               end
               lock_phase_in = LOCK_IDLE;
               rd = {15'd0, lock_active_in, lock_mask_ff};
            end
            default: rd = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_fields_ff  <= '0;
         type_fields_ff  <= '0;
         speed_fields_ff <= '0;
         pull_fields_ff  <= '0;
         output_latch_ff <= '0;
         input_sample_ff <= '0;
         lock_mask_ff    <= '0;
         lock_active_ff  <= 1'b0;
         lock_phase_ff   <= LOCK_IDLE;
      end else if (step) begin
         mode_fields_ff  <= mode_fields_in;
         type_fields_ff  <= type_fields_in;
         speed_fields_ff <= speed_fields_in;
         pull_fields_ff  <= pull_fields_in;
         output_latch_ff <= output_latch_in;
         input_sample_ff <= input_sample_in;
         lock_mask_ff    <= lock_mask_in;
         lock_active_ff  <= lock_active_in;
         lock_phase_ff   <= lock_phase_in;
      end
   end

   assign rsp.read_data         = rd;
   assign rsp.pin_drive         = output_latch_in;
   assign rsp.pin_output_enable = output_enable(mode_fields_in);

   `GPB_ASSERT_NEXT(lock_sticky, lock_active_ff, lock_active_ff)
   `GPB_ASSERT_NEXT(locked_mode_hold, lock_active_ff,
      (mode_fields_ff & field_mask(lock_mask_ff)) == $past(mode_fields_ff & field_mask(lock_mask_ff)))
   `GPB_ASSERT_IMPL(lock_rise_on_key, $rose(lock_active_ff),
      $past(step && req.mode == ACC_READ && req.reg_index == REG_LOCK && lock_phase_ff == LOCK_ARMED))
   `GPB_ASSERT_NEXT(sample_idle_hold, !step, $stable(input_sample_ff))

endmodule

@@ hdl/gpb_rsp_reg.sv @@
// Result output register for the GPIO port register bank.
// Depends on gpb_pkg.
module gpb_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  gpb_pkg::rsp_type rsp_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             free,
   output gpb_pkg::rsp_type rsp_out
);
   import gpb_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   // slot frees up when empty or its transfer completes this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

@@ hdl/gpio_port_register_bank_core.sv @@
// 16-pin GPIO port register bank: one register access per request, one result each.
// Result path: the request passes the input register, then the result register.
// Throughput: one access per cycle unless rsp_stall; state update and decode sit between them.
// A stalled result holds the input register; both keep one item each.
// Reset is synchronous, active high; clears all port fields, the lock and both valid flags.
// Depends on gpb_pkg, gpb_req_reg, gpb_reg_bank, gpb_rsp_reg and assert_macros.svh.
`include "assert_macros.svh"
module gpio_port_register_bank_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [15:0] rsp_pin_drive,
   output logic [15:0] rsp_pin_output_enable
);
   import gpb_pkg::*;

   req_type req_in;
   req_type held_req;
   rsp_type bank_rsp;
   rsp_type rsp_out;
   logic    held_valid;
   logic    slot_free;
   logic    step;

   assign req_in.mode       = req_mode;
   assign req_in.reg_index  = req_reg_index;
   assign req_in.write_data = req_write_data;
   assign req_in.pin_levels = req_pin_levels;

   assign step = held_valid && slot_free;

   gpb_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_in     (req_in),
      .take       (step),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   gpb_reg_bank u_bank (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (held_req),
      .rsp   (bank_rsp)
   );

   gpb_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .rsp_in    (bank_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .free      (slot_free),
      .rsp_out   (rsp_out)
   );

   assign rsp_read_data         = rsp_out.read_data;
   assign rsp_pin_drive         = rsp_out.pin_drive;
   assign rsp_pin_output_enable = rsp_out.pin_output_enable;

   `GPB_ASSERT_IMPL(stall_only_when_full, req_stall, held_valid && rsp_valid && rsp_stall)
   `GPB_ASSERT_NEXT(step_gives_result, step, rsp_valid)

endmodule
